// File: rtl/core/reb_pkg.sv
// Shared types and constants for the rotary encoder and button decoder.
package reb_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TIMER_WIDTH_DEF = 21;

  localparam int CFG_TICKS_W = 20;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] PAT_CW  = 8'b0100_1011;
  localparam logic [7:0] PAT_CCW = 8'b1000_0111;

  localparam logic [CFG_TICKS_W-1:0] DEBOUNCE_RST = 20'd5000;
  localparam logic [CFG_TICKS_W-1:0] DOUBLE_RST   = 20'd500000;
  localparam logic [1:0]             PINS_IDLE    = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DOUBLE   = 2'd1,
    CFG_BTN_EN   = 2'd2
  } cfg_idx_e;

  // status flag bit positions
  localparam int FLG_MOVED   = 0;
  localparam int FLG_PRESSED = 1;
  localparam int FLG_CLICKED = 2;
  localparam int FLG_DOUBLE  = 3;

  typedef struct packed {
    logic               pin_a;
    logic               pin_b;
    logic               button_level;
    logic               ack_moved;
    logic               ack_pressed;
    logic               ack_clicked;
    logic               ack_double;
    logic               clear_diff;
    logic               clear_flags;
    logic               load_count;
    logic signed [15:0] new_count;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic signed [15:0] detent_diff;
    logic               moved;
    logic               pressed;
    logic               clicked;
    logic               double_clicked;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_TICKS_W-1:0] data;
  } cfg_item_t;

endpackage

// File: rtl/core/reb_if.sv
// Valid/ready channel interfaces for tick items, results and config writes.
interface reb_in_if import reb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface reb_out_if import reb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface reb_cfg_if import reb_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/rotary_encoder_button_input.sv
// Quadrature encoder and debounced push-button decoder, one result per tick.
//
//  channel | dir | payload                               | beat when
//  in_i    | in  | pins, button level, acks, load value  | valid & ready
//  res_o   | out | position, diff, four sticky flags     | valid & ready
//  cfg_i   | in  | register index, 20-bit data           | valid (ready tied high)
//
// One tick per cycle while res_o does not stall: state updates in the cycle
// a tick beat lands, and the result sits in one output register.
// in_i stays ready while the result register is empty or being drained.
// A stall on res_o holds the result and backs up in_i until it is taken.
// Reset: history 0, pins idle high, button released, timers saturated.
module rotary_encoder_button_input
  import reb_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  reb_in_if.sink    in_i,
  reb_out_if.source res_o,
  reb_cfg_if.sink   cfg_i
);

  logic [CFG_TICKS_W-1:0] debounce_q, double_q;
  logic                   btn_en_q;

  logic [7:0]             hist_q, hist_d, hist_n;
  logic [1:0]             pins_q, pins;
  logic                   raw_q, btn_deb_q, btn_deb_d;
  logic [TIMER_WIDTH-1:0] sd_q, sd_d, sd_inc;
  logic [TIMER_WIDTH-1:0] sr_q, sr_d, sr_inc;
  logic [COUNT_WIDTH-1:0] pos_q, pos_d, pos_ld;
  logic [COUNT_WIDTH-1:0] diff_q, diff_n, diff_d;
  logic [3:0]             flags_q, flags_n, flags_d, acks;

  logic [31:0]            nc_ext, pos_ext, diff_ext;
  logic                   in_beat, pins_chg, cw, ccw;
  logic                   btn_acc, release_ev, press_ev, dbl_ev;

  out_item_t              res_q, res_d;
  logic                   res_valid_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      double_q   <= DOUBLE_RST;
      btn_en_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        CFG_DEBOUNCE: debounce_q <= cfg_i.payload.data;
        CFG_DOUBLE:   double_q   <= cfg_i.payload.data;
        CFG_BTN_EN:   btn_en_q   <= cfg_i.payload.data[0];
        default:      ;
      endcase
    end
  end

  assign in_i.ready = !res_valid_q || res_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;

  always_comb begin
    sd_inc = (sd_q == {TIMER_WIDTH{1'b1}}) ? sd_q : sd_q + TIMER_WIDTH'(1);
    sr_inc = (sr_q == {TIMER_WIDTH{1'b1}}) ? sr_q : sr_q + TIMER_WIDTH'(1);

    nc_ext = 32'(signed'(in_i.payload.new_count));
    pos_ld = in_i.payload.load_count ? nc_ext[COUNT_WIDTH-1:0] : pos_q;

    pins     = {in_i.payload.pin_a, in_i.payload.pin_b};
    pins_chg = (pins != pins_q);
    hist_n   = {hist_q[5:0], pins};
    hist_d   = pins_chg ? hist_n : hist_q;
    cw       = pins_chg && (hist_n == PAT_CW);
    ccw      = pins_chg && (hist_n == PAT_CCW);

    pos_d  = cw ? pos_ld + COUNT_WIDTH'(1) : (ccw ? pos_ld - COUNT_WIDTH'(1) : pos_ld);
    diff_n = cw ? diff_q + COUNT_WIDTH'(1) : (ccw ? diff_q - COUNT_WIDTH'(1) : diff_q);

    // debounce compares the already-advanced elapsed count
    btn_acc    = btn_en_q && (in_i.payload.button_level != raw_q)
                 && (32'(sd_inc) >= 32'(debounce_q));
    release_ev = btn_acc && !btn_deb_q && in_i.payload.button_level;
    press_ev   = btn_acc && btn_deb_q && !in_i.payload.button_level;
    dbl_ev     = release_ev && (32'(sr_inc) <= 32'(double_q));
    btn_deb_d  = btn_acc ? in_i.payload.button_level : btn_deb_q;
    sd_d       = btn_acc ? '0 : sd_inc;
    sr_d       = release_ev ? '0 : sr_inc;

    flags_n = flags_q;
    if (cw || ccw) flags_n[FLG_MOVED] = 1'b1;
    if (press_ev)  flags_n[FLG_PRESSED] = 1'b1;
    if (release_ev) flags_n[FLG_CLICKED] = 1'b1;
    if (dbl_ev)    flags_n[FLG_DOUBLE] = 1'b1;

    acks = {in_i.payload.ack_double, in_i.payload.ack_clicked,
            in_i.payload.ack_pressed, in_i.payload.ack_moved};
    flags_d = in_i.payload.clear_flags ? 4'b0000 : (flags_n & ~acks);
    diff_d  = in_i.payload.clear_diff ? '0 : diff_n;

    pos_ext  = 32'(pos_d);
    diff_ext = 32'(diff_n);
    res_d.position       = pos_ext[15:0];
    res_d.detent_diff    = diff_ext[15:0];
    res_d.moved          = flags_n[FLG_MOVED];
    res_d.pressed        = flags_n[FLG_PRESSED];
    res_d.clicked        = flags_n[FLG_CLICKED];
    res_d.double_clicked = flags_n[FLG_DOUBLE];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      pins_q    <= PINS_IDLE;
      raw_q     <= 1'b1;
      btn_deb_q <= 1'b1;
      sd_q      <= '1;
      sr_q      <= '1;
      pos_q     <= '0;
      diff_q    <= '0;
      flags_q   <= '0;
    end else if (in_beat) begin
      hist_q    <= hist_d;
      pins_q    <= pins;
      raw_q     <= in_i.payload.button_level;
      btn_deb_q <= btn_deb_d;
      sd_q      <= sd_d;
      sr_q      <= sr_d;
      pos_q     <= pos_d;
      diff_q    <= diff_d;
      flags_q   <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_beat) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

`ifndef ASSERT_OFF
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> res_valid_q)
    else $error("tick beat did not load a result");

  a_clear_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_i.payload.clear_diff |=> diff_q == '0)
    else $error("diff not zeroed after clear");

  a_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_i.payload.clear_flags |=> flags_q == 4'b0000)
    else $error("flags not cleared");

  a_moved_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && flags_q[FLG_MOVED] && !in_i.payload.ack_moved && !in_i.payload.clear_flags
    |=> flags_q[FLG_MOVED])
    else $error("moved flag dropped without acknowledge");
`endif

endmodule
